>>> rtl/core/cts_pkg.sv
`timescale 1ns / 1ps
package cts_pkg;

	typedef enum logic [4:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_MINUS, M_PLUS, M_STAR, M_SLASH, M_PCT,
		M_AMP, M_BAR, M_CARET, M_LT, M_LTLT, M_GT, M_GTGT, M_EQ, M_BANG, M_ERROR
	} mode_t;

	localparam logic [5:0] KIND_EOF     = 6'd0;
	localparam logic [5:0] KIND_KEYWORD = 6'd1;
	localparam logic [5:0] KIND_IDENT   = 6'd2;
	localparam logic [5:0] KIND_INT     = 6'd3;
	localparam logic [5:0] KIND_ERROR   = 6'd43;
	localparam logic [30:0] INT_LIMIT   = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [5:0]  kind;
		logic [2:0]  kw;
		logic [30:0] val;
		logic        ovf;
		logic [19:0] start;
		logic [19:0] len;
		logic        last;
	} token_t;

	function automatic logic [5:0] op_alone(mode_t m);
		case (m)
			M_MINUS: return 6'd10;
			M_PLUS:  return 6'd13;
			M_STAR:  return 6'd16;
			M_SLASH: return 6'd18;
			M_PCT:   return 6'd20;
			M_AMP:   return 6'd22;
			M_BAR:   return 6'd25;
			M_CARET: return 6'd28;
			M_LT:    return 6'd30;
			M_LTLT:  return 6'd32;
			M_GT:    return 6'd34;
			M_GTGT:  return 6'd36;
			M_EQ:    return 6'd38;
			M_BANG:  return 6'd40;
			default: return 6'd0;
		endcase
	endfunction

	// keyword character at a given index, zero past the end
	function automatic logic [7:0] kw_char(logic [2:0] k, logic [2:0] i);
		case (k)
			3'd0: case (i) 3'd0: return "i"; 3'd1: return "n"; 3'd2: return "t";
				default: return 8'd0; endcase
			3'd1: case (i) 3'd0: return "v"; 3'd1: return "o"; 3'd2: return "i";
				3'd3: return "d"; default: return 8'd0; endcase
			3'd2: case (i) 3'd0: return "r"; 3'd1: return "e"; 3'd2: return "t";
				3'd3: return "u"; 3'd4: return "r"; 3'd5: return "n";
				default: return 8'd0; endcase
			3'd3: case (i) 3'd0: return "i"; 3'd1: return "f";
				default: return 8'd0; endcase
			3'd4: case (i) 3'd0: return "e"; 3'd1: return "l"; 3'd2: return "s";
				3'd3: return "e"; default: return 8'd0; endcase
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [2:0] kw_len(logic [2:0] k);
		case (k)
			3'd0: return 3'd3;
			3'd1: return 3'd4;
			3'd2: return 3'd6;
			3'd3: return 3'd2;
			default: return 3'd4;
		endcase
	endfunction

endpackage

>>> rtl/core/c_subset_token_scanner_unit.sv
`timescale 1ns / 1ps
// Byte-stream C-subset scanner: one source byte is taken per cycle while full is low,
// and each byte yields zero, one or two tokens into a four-entry result queue.
// full rises when fewer than two queue slots are free, so throughput is one byte
// per cycle as long as pop keeps up, since the classifier updates its state on every
// taken byte. Offsets wrap modulo MAX_SOURCE_BYTES.
module c_subset_token_scanner_unit #(
	parameter longint MAX_SOURCE_BYTES = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  token_kind,
	output logic [2:0]  keyword_code,
	output logic [30:0] int_value,
	output logic        int_overflow,
	output logic [19:0] text_start,
	output logic [19:0] text_length,
	output logic        last_of_run
);
	import cts_pkg::*;

	localparam int POS_W = $clog2(MAX_SOURCE_BYTES);

	logic       room, take, ev;
	logic [1:0] ec;
	token_t     ea, eb, head;

	assign full = !room;
	assign take = push && room;

	cts_front #(.POS_W(POS_W), .SRC_BYTES(MAX_SOURCE_BYTES)) u_front (
		.clk, .arst_n, .take, .source_byte, .end_of_input,
		.emit_valid(ev), .emit_count(ec), .emit_a(ea), .emit_b(eb)
	);

	cts_queue u_queue (
		.clk, .arst_n, .wr(ev), .wr_count(ec), .wr_a(ea), .wr_b(eb),
		.room, .empty, .pop, .head
	);

	assign token_kind   = head.kind;
	assign keyword_code = head.kw;
	assign int_value    = head.val;
	assign int_overflow = head.ovf;
	assign text_start   = head.start;
	assign text_length  = head.len;
	assign last_of_run  = head.last;
endmodule

>>> rtl/core/cts_front.sv
`timescale 1ns / 1ps
module cts_front #(
	parameter int     POS_W     = 20,
	parameter longint SRC_BYTES = 1048576
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       source_byte,
	input  logic             end_of_input,
	output logic             emit_valid,
	output logic [1:0]       emit_count,
	output cts_pkg::token_t  emit_a,
	output cts_pkg::token_t  emit_b
);
	import cts_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX  = POS_W'(SRC_BYTES - 64'd1);
	localparam logic [POS_W-1:0] POS_WRAP = POS_W'(SRC_BYTES);

	mode_t            mode_q, mode_d;
	logic [30:0]      acc_q, acc_d;
	logic             sat_q, sat_d;
	logic [4:0]       cand_q, cand_d;
	logic [POS_W-1:0] pos_q, begin_q, begin_d;

	logic [POS_W-1:0] len_cur;
	logic [34:0]      acc_mul;
	logic [7:0]       c;
	logic             is_start, is_digit, is_eoi, taken;
	token_t           flush_tok, tok [2];
	logic             flush_has;
	logic [1:0]       n;
	logic [5:0]       single;
	mode_t            op_mode;

	assign c        = source_byte;
	assign is_eoi   = end_of_input || (c == 8'd0);
	assign is_start = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	assign is_digit = c >= "0" && c <= "9";
	// span across the wrap of the byte offset
	assign len_cur  = (pos_q >= begin_q) ? pos_q - begin_q : pos_q + POS_WRAP - begin_q;
	assign acc_mul  = {acc_q, 3'b0} + {2'b0, acc_q, 1'b0};

	function automatic logic [4:0] filter(logic [4:0] cand, logic [POS_W-1:0] idx,
			logic [7:0] ch);
		logic [4:0] r;
		r = '0;
		for (int k = 0; k < 5; k++)
			if (cand[k] && idx < POS_W'(kw_len(3'(k))) &&
					kw_char(3'(k), idx[2:0]) == ch)
				r[k] = 1'b1;
		return r;
	endfunction

	function automatic token_t mk(logic [5:0] kind, logic [2:0] kw, logic [30:0] v,
			logic o, logic [POS_W-1:0] s, logic [POS_W-1:0] l);
		token_t t;
		t.kind  = kind;
		t.kw    = kw;
		t.val   = v;
		t.ovf   = o;
		t.start = 20'(s);
		t.len   = 20'(l);
		t.last  = 1'b0;
		return t;
	endfunction

	always_comb begin
		flush_has = 1'b0;
		flush_tok = mk(KIND_EOF, 3'd0, 31'd0, 1'b0, begin_q, len_cur);
		if (mode_q == M_IDENT) begin
			flush_has = 1'b1;
			flush_tok = mk(KIND_IDENT, 3'd0, 31'd0, 1'b0, begin_q, len_cur);
			for (int k = 4; k >= 0; k--)
				if (cand_q[k] && len_cur == POS_W'(kw_len(3'(k))))
					flush_tok = mk(KIND_KEYWORD, 3'(k), 31'd0, 1'b0, begin_q, len_cur);
		end else if (mode_q == M_NUMBER) begin
			flush_has = 1'b1;
			flush_tok = mk(KIND_INT, 3'd0, acc_q, sat_q, begin_q, len_cur);
		end else if (mode_q >= M_MINUS && mode_q <= M_BANG) begin
			flush_has = 1'b1;
			flush_tok = mk(op_alone(mode_q), 3'd0, 31'd0, 1'b0, begin_q, len_cur);
		end
	end

	always_comb begin
		single = 6'd0;
		op_mode = M_IDLE;
		case (c)
			"(": single = 6'd4;
			")": single = 6'd5;
			"{": single = 6'd6;
			"}": single = 6'd7;
			";": single = 6'd8;
			"~": single = 6'd9;
			"-": op_mode = M_MINUS;
			"+": op_mode = M_PLUS;
			"*": op_mode = M_STAR;
			"/": op_mode = M_SLASH;
			"%": op_mode = M_PCT;
			"&": op_mode = M_AMP;
			"|": op_mode = M_BAR;
			"^": op_mode = M_CARET;
			"<": op_mode = M_LT;
			">": op_mode = M_GT;
			"=": op_mode = M_EQ;
			"!": op_mode = M_BANG;
			default: ;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		sat_d   = sat_q;
		cand_d  = cand_q;
		begin_d = begin_q;
		n       = 2'd0;
		tok[0]  = flush_tok;
		tok[1]  = flush_tok;
		taken   = 1'b0;
		if (is_eoi) begin
			if (flush_has) begin
				tok[0] = flush_tok;
				n = 2'd1;
			end
			tok[n[0]] = mk(KIND_EOF, 3'd0, 31'd0, 1'b0, pos_q, '0);
			n = n + 2'd1;
			mode_d = M_IDLE; acc_d = '0; sat_d = 1'b0; cand_d = 5'h1F; begin_d = '0;
		end else if (mode_q != M_ERROR) begin
			if (mode_q == M_IDENT) begin
				if (is_start || is_digit) begin
					taken = 1'b1;
					cand_d = filter(cand_q, len_cur, c);
				end
			end else if (mode_q == M_NUMBER) begin
				if (is_digit) begin
					taken = 1'b1;
					if (acc_mul + 35'(c - "0") > 35'(INT_LIMIT)) begin
						acc_d = INT_LIMIT;
						sat_d = 1'b1;
					end else
						acc_d = 31'(acc_mul + 35'(c - "0"));
				end
			end else if (mode_q >= M_MINUS && mode_q <= M_BANG) begin
				if (c == "=") begin
					taken = 1'b1;
					tok[0] = mk(op_alone(mode_q) + 6'd2 - ((mode_q == M_STAR ||
						mode_q == M_SLASH || mode_q == M_PCT || mode_q == M_CARET ||
						mode_q == M_LT || mode_q == M_GT || mode_q == M_EQ ||
						mode_q == M_BANG || mode_q == M_LTLT || mode_q == M_GTGT)
						? 6'd1 : 6'd0), 3'd0, 31'd0, 1'b0, begin_q, len_cur + 1'b1);
					n = 2'd1;
					mode_d = M_IDLE;
				end else if ((mode_q == M_MINUS && c == "-") ||
						(mode_q == M_PLUS && c == "+") ||
						(mode_q == M_AMP && c == "&") ||
						(mode_q == M_BAR && c == "|")) begin
					taken = 1'b1;
					tok[0] = mk(op_alone(mode_q) + 6'd1, 3'd0, 31'd0, 1'b0, begin_q,
						len_cur + 1'b1);
					n = 2'd1;
					mode_d = M_IDLE;
				end else if (mode_q == M_LT && c == "<") begin
					taken = 1'b1;
					mode_d = M_LTLT;
				end else if (mode_q == M_GT && c == ">") begin
					taken = 1'b1;
					mode_d = M_GTGT;
				end
			end
			if (!taken) begin
				if (flush_has) begin
					tok[0] = flush_tok;
					n = 2'd1;
				end
				mode_d = M_IDLE;
				if (!(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
					begin_d = pos_q;
					if (single != 6'd0) begin
						tok[n[0]] = mk(single, 3'd0, 31'd0, 1'b0, pos_q, POS_W'(1));
						n = n + 2'd1;
					end else if (op_mode != M_IDLE) begin
						mode_d = op_mode;
					end else if (is_start) begin
						mode_d = M_IDENT;
						cand_d = filter(5'h1F, '0, c);
					end else if (is_digit) begin
						mode_d = M_NUMBER;
						acc_d = 31'(c - "0");
						sat_d = 1'b0;
					end else begin
						tok[n[0]] = mk(KIND_ERROR, 3'd0, 31'd0, 1'b0, pos_q, POS_W'(1));
						n = n + 2'd1;
						mode_d = M_ERROR;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			cand_q  <= 5'h1F;
			pos_q   <= '0;
			begin_q <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			sat_q   <= sat_d;
			cand_q  <= cand_d;
			begin_q <= begin_d;
			if (is_eoi)
				pos_q <= '0;
			else
				pos_q <= (pos_q == POS_MAX) ? '0 : pos_q + 1'b1;
		end
	end

	always_comb begin
		emit_valid = take && n != 2'd0;
		emit_count = n;
		emit_a = tok[0];
		emit_b = tok[1];
		emit_a.last = (n == 2'd1);
		emit_b.last = 1'b1;
	end

endmodule

>>> rtl/core/cts_queue.sv
`timescale 1ns / 1ps
module cts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  logic [1:0]      wr_count,
	input  cts_pkg::token_t wr_a,
	input  cts_pkg::token_t wr_b,
	output logic            room,
	output logic            empty,
	input  logic            pop,
	output cts_pkg::token_t head
);
	import cts_pkg::*;

	token_t     mem_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       do_pop;

	assign empty  = cnt_q == 3'd0;
	assign do_pop = pop && !empty;
	// two free slots needed since an item may cause two tokens
	assign room   = cnt_q <= 3'd2;
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= wr_a;
			if (wr_count == 2'd2)
				mem_q[wr_q + 2'd1] <= wr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wr_q <= wr_q + wr_count;
			if (do_pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (wr ? {1'b0, wr_count} : 3'd0) - {2'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("queue count beyond depth");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> room) else $error("write without room");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !wr |=> cnt_q == $past(cnt_q) - 3'd1) else $error("pop lost");
endmodule

>>> tb/sv/tb_c_subset_token_scanner_unit.sv
`timescale 1ns / 1ps
module tb_c_subset_token_scanner_unit;
	import cts_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint SRC_WRAP = 1048576;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		int         hold;
	} src_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  source_byte = 8'd0;
	logic        end_of_input = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [5:0]  token_kind;
	logic [2:0]  keyword_code;
	logic [30:0] int_value;
	logic        int_overflow;
	logic [19:0] text_start;
	logic [19:0] text_length;
	logic        last_of_run;

	c_subset_token_scanner_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.source_byte(source_byte), .end_of_input(end_of_input),
		.empty(empty), .pop(pop), .token_kind(token_kind),
		.keyword_code(keyword_code), .int_value(int_value),
		.int_overflow(int_overflow), .text_start(text_start),
		.text_length(text_length), .last_of_run(last_of_run)
	);

	always #10 clk = ~clk;

	src_item_t pending_bytes[$];
	token_t    expected_tokens[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        pop_holdoff = 0;
	int        rx_cycles = 0;

	// scanner state mirrored for prediction
	mode_t       sc_mode;
	logic [30:0] sc_acc;
	logic        sc_sat;
	logic [4:0]  sc_cand;
	longint      sc_pos;
	longint      sc_begin;

	function automatic logic [5:0] alone_kind(mode_t m);
		case (m)
			M_MINUS: return 6'd10; M_PLUS: return 6'd13; M_STAR: return 6'd16;
			M_SLASH: return 6'd18; M_PCT: return 6'd20; M_AMP: return 6'd22;
			M_BAR: return 6'd25; M_CARET: return 6'd28; M_LT: return 6'd30;
			M_LTLT: return 6'd32; M_GT: return 6'd34; M_GTGT: return 6'd36;
			M_EQ: return 6'd38; M_BANG: return 6'd40; default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] assign_kind(mode_t m);
		return alone_kind(m) + ((m == M_MINUS || m == M_PLUS || m == M_AMP
			|| m == M_BAR) ? 6'd2 : 6'd1);
	endfunction

	function automatic string kw_word(int k);
		case (k)
			0: return "int"; 1: return "void"; 2: return "return";
			3: return "if"; default: return "else";
		endcase
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic longint span_to(longint e);
		return e >= sc_begin ? e - sc_begin : e + SRC_WRAP - sc_begin;
	endfunction

	function automatic logic [4:0] narrow_keywords(logic [4:0] cand, longint idx,
			logic [7:0] c);
		logic [4:0] r;
		string w;
		r = 5'd0;
		for (int k = 0; k < 5; k++) begin
			w = kw_word(k);
			if (cand[k] && idx < w.len() && w[idx] == c)
				r[k] = 1'b1;
		end
		return r;
	endfunction

	function automatic void emit(logic [5:0] kind, logic [2:0] kw, logic [30:0] val,
			logic ovf, longint start, longint len);
		token_t t;
		t.kind = kind; t.kw = kw; t.val = val; t.ovf = ovf;
		t.start = start[19:0]; t.len = len[19:0]; t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void accumulate(logic [7:0] c);
		longint v;
		v = longint'(sc_acc) * 10 + (c - "0");
		if (v > longint'(INT_LIMIT)) begin
			sc_acc = INT_LIMIT;
			sc_sat = 1'b1;
		end else
			sc_acc = v[30:0];
	endfunction

	function automatic void flush_pending();
		longint len;
		bit done;
		string w;
		len = span_to(sc_pos);
		done = 0;
		if (sc_mode == M_IDENT) begin
			for (int k = 0; k < 5 && !done; k++) begin
				w = kw_word(k);
				if (sc_cand[k] && len == w.len()) begin
					emit(KIND_KEYWORD, k[2:0], 0, 0, sc_begin, len);
					done = 1;
				end
			end
			if (!done)
				emit(KIND_IDENT, 0, 0, 0, sc_begin, len);
		end else if (sc_mode == M_NUMBER)
			emit(KIND_INT, 0, sc_acc, sc_sat, sc_begin, len);
		else if (sc_mode >= M_MINUS && sc_mode <= M_BANG)
			emit(alone_kind(sc_mode), 0, 0, 0, sc_begin, len);
		if (sc_mode != M_ERROR)
			sc_mode = M_IDLE;
	endfunction

	task automatic open_token(logic [7:0] c);
		logic [5:0] single;
		mode_t m;
		single = 0;
		m = M_IDLE;
		case (c)
			" ", "\t", 8'd13, "\n": return;
			"(": single = 6'd4; ")": single = 6'd5; "{": single = 6'd6;
			"}": single = 6'd7; ";": single = 6'd8; "~": single = 6'd9;
			"-": m = M_MINUS; "+": m = M_PLUS; "*": m = M_STAR; "/": m = M_SLASH;
			"%": m = M_PCT; "&": m = M_AMP; "|": m = M_BAR; "^": m = M_CARET;
			"<": m = M_LT; ">": m = M_GT; "=": m = M_EQ; "!": m = M_BANG;
			default: ;
		endcase
		sc_begin = sc_pos;
		if (single != 0)
			emit(single, 0, 0, 0, sc_pos, 1);
		else if (m != M_IDLE)
			sc_mode = m;
		else if (is_letter(c)) begin
			sc_mode = M_IDENT;
			sc_cand = narrow_keywords(5'h1F, 0, c);
		end else if (is_num(c)) begin
			sc_mode = M_NUMBER;
			sc_acc = 0;
			sc_sat = 0;
			accumulate(c);
		end else begin
			emit(KIND_ERROR, 0, 0, 0, sc_pos, 1);
			sc_mode = M_ERROR;
		end
	endtask

	function automatic logic [7:0] doubling_char(mode_t m);
		case (m)
			M_MINUS: return "-"; M_PLUS: return "+"; M_AMP: return "&";
			M_BAR: return "|"; M_LT: return "<"; M_GT: return ">";
			default: return 8'd0;
		endcase
	endfunction

	function automatic bit extend_token(logic [7:0] c);
		longint len;
		if (sc_mode == M_IDENT) begin
			if (is_letter(c) || is_num(c)) begin
				sc_cand = narrow_keywords(sc_cand, span_to(sc_pos), c);
				return 1;
			end
		end else if (sc_mode == M_NUMBER) begin
			if (is_num(c)) begin
				accumulate(c);
				return 1;
			end
		end else if (sc_mode >= M_MINUS && sc_mode <= M_BANG) begin
			len = span_to(sc_pos) + 1;
			if (c == "=") begin
				emit(assign_kind(sc_mode), 0, 0, 0, sc_begin, len);
				sc_mode = M_IDLE;
				return 1;
			end
			if (doubling_char(sc_mode) != 0 && c == doubling_char(sc_mode)) begin
				if (sc_mode == M_LT)
					sc_mode = M_LTLT;
				else if (sc_mode == M_GT)
					sc_mode = M_GTGT;
				else begin
					emit(alone_kind(sc_mode) + 6'd1, 0, 0, 0, sc_begin, len);
					sc_mode = M_IDLE;
				end
				return 1;
			end
		end
		flush_pending();
		return 0;
	endfunction

	task automatic clear_scanner();
		sc_mode = M_IDLE; sc_acc = 0; sc_sat = 0; sc_cand = 5'h1F;
		sc_pos = 0; sc_begin = 0;
	endtask

	task automatic predict_tokens(logic [7:0] c, logic eoi);
		int tokens_prior;
		tokens_prior = expected_tokens.size();
		if (eoi || c == 0) begin
			flush_pending();
			emit(KIND_EOF, 0, 0, 0, sc_pos, 0);
			clear_scanner();
		end else begin
			if (sc_mode != M_ERROR)
				if (sc_mode == M_IDLE || !extend_token(c))
					open_token(c);
			sc_pos = (sc_pos + 1) % SRC_WRAP;
		end
		if (expected_tokens.size() > tokens_prior)
			expected_tokens[$].last = 1'b1;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic queue_byte(logic [7:0] c, logic eoi = 0, int hold = -1);
		src_item_t it;
		it.ch = c; it.eoi = eoi; it.hold = hold < 0 ? gap_len() : hold;
		pending_bytes.push_back(it);
	endtask

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	function automatic string random_word();
		string pieces[] = '{"int", "void", "return", "if", "else", "in", "iff", "voids",
			"_x9", "Zed", "returnx", "els", "i", "int1", "elsee", "ret"};
		string s;
		s = pieces[$urandom_range(0, pieces.size() - 1)];
		if ($urandom_range(0, 3) == 0)
			for (int i = $urandom_range(1, 8); i > 0; i--)
				s = {s, string'(8'("a" + $urandom_range(0, 25)))};
		return s;
	endfunction

	function automatic string random_token();
		string ops[] = '{"(", ")", "{", "}", ";", "~", "-", "--", "-=", "+", "++", "+=",
			"*", "*=", "/", "/=", "%", "%=", "&", "&&", "&=", "|", "||", "|=", "^", "^=",
			"<", "<=", "<<", "<<=", ">", ">=", ">>", ">>=", "=", "==", "!", "!=",
			" ", "\t", "\n", "\015"};
		string s;
		case ($urandom_range(0, 3))
			0: return random_word();
			1: begin
				s = "";
				for (int i = $urandom_range(1, $urandom_range(0, 5) == 0 ? 14 : 4); i > 0; i--)
					s = {s, string'(8'("0" + $urandom_range(0, 9)))};
				return s;
			end
			default: return ops[$urandom_range(0, ops.size() - 1)];
		endcase
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_bytes.size() != 0 && pending_bytes[0].hold > 0) begin
				pending_bytes[0].hold--;
				push <= 1'b0;
			end else if (pending_bytes.size() != 0 && pending_bytes[0].hold < -1) begin
				// wait for the scanner to drain completely
				push <= 1'b0;
				if (expected_tokens.size() == 0)
					pending_bytes[0].hold = 0;
			end else if (pending_bytes.size() != 0) begin
				push <= 1'b1;
				source_byte <= pending_bytes[0].ch;
				end_of_input <= pending_bytes[0].eoi;
			end else
				push <= 1'b0;
		end
	end

	// receiver: random pop stalls, one long hold-off early on
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycles++;
			if (rx_cycles == 50)
				pop_holdoff = 200;
			else if (pop_holdoff == 0 && $urandom_range(0, 99) < 3)
				pop_holdoff = gap_len();
			if (pop_holdoff > 0) begin
				pop_holdoff--;
				pop <= 1'b0;
			end else
				pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 40) == 0 ? 0 : 1);
		end
	end

	// monitor
	always @(posedge clk) begin
		token_t want;
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (push && !full) begin
				predict_tokens(source_byte, end_of_input);
				void'(pending_bytes.pop_front());
			end
			if (pop && !empty) begin
				if (expected_tokens.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token kind %0d start %0d", token_kind, text_start);
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind !== want.kind || keyword_code !== want.kw
							|| int_value !== want.val || int_overflow !== want.ovf
							|| text_start !== want.start || text_length !== want.len
							|| last_of_run !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: expected %0d/%0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d/%0d",
								want.kind, want.kw, want.val, want.ovf, want.start, want.len,
								want.last, token_kind, keyword_code, int_value, int_overflow,
								text_start, text_length, last_of_run);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_c_subset_token_scanner_unit failed");
			$finish;
		end
	end

	initial begin
		string s;
		clear_scanner();
		// directed: keywords, near misses, every operator, numbers, errors, eoi forms
		queue_text("int void return if else in iff elsee ifx _A9z;");
		queue_text("(){}~ - -- -= + ++ += * *= / /= % %= & && &= | || |= ^ ^=");
		queue_text("< <= << <<= > >= >> >>= = == ! != ---<<<>>>===");
		queue_text("0 2147483647 2147483648 99999999999 ");
		queue_byte(8'd0);
		queue_text("x+");
		queue_byte(8'd0, 1);
		queue_text("a@b c");
		queue_byte(8'hFF);
		queue_byte(8'd0, 1);
		queue_byte(8'h80);
		queue_byte(8'h55, 1);
		queue_text("12");
		queue_byte(8'hAA, 1, -2);
		// random part: mostly well-formed text, some noise and broken runs
		for (int n = 0; n < 25; n++) begin
			s = "";
			for (int i = $urandom_range(2, 25); i > 0; i--) begin
				s = {s, random_token()};
				if ($urandom_range(0, 2) == 0) s = {s, " "};
			end
			if ($urandom_range(0, 9) == 0)
				s = {s, string'(8'($urandom_range(1, 255)))};
			queue_text(s);
			if (n == 10)
				pending_bytes[$].hold = 0;
			if ($urandom_range(0, 4) != 0)
				queue_byte(8'($urandom_range(0, 255)), 1);
			else
				queue_byte(8'd0);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_bytes.size() == 0);
		wait (expected_tokens.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("tb_c_subset_token_scanner_unit passed");
		else
			$display("tb_c_subset_token_scanner_unit failed");
		$finish;
	end

endmodule
